### design/mppt_pkg.sv
package mppt_pkg;

  // Widths fixed by the sample and result formats
  localparam int VW    = 16;   // Q8.8 voltage / current
  localparam int PW    = 32;   // Q16.16 power
  localparam int DW    = 24;   // Q0.24 duty and step
  localparam int BW    = 21;   // base step
  localparam int XW    = 35;   // CORDIC x/y datapath, signed
  localparam int ZW    = 16;   // CORDIC angle, signed Q2.14
  localparam int ZMW   = 15;   // angle magnitude
  localparam int DPW   = BW + ZMW;        // base_step * |angle|
  localparam int TW    = 22;              // rounded product >> 15
  localparam int SW    = 26;              // signed step / duty arithmetic
  localparam int ANGLE_IDX_W = 5;
  localparam int CORDIC_ITER_DEF = 16;

  localparam logic [DPW:0] ROUND_HALF = (DPW+1)'(81920);
  localparam logic [DW-1:0] DUTY_ALL_ONES = {DW{1'b1}};

  typedef enum logic [1:0] {
    REG_START_DUTY   = 2'd0,
    REG_DUTY_MAX     = 2'd1,
    REG_DUTY_MIN     = 2'd2,
    REG_BASE_STEP    = 2'd3
  } reg_idx_t;

  // atan(2^-i) in Q2.14, rounded to nearest
  function automatic logic [ZW-1:0] angle_q14(input logic [ANGLE_IDX_W-1:0] idx);
    logic [ZW-1:0] a;
    case (idx)
      5'd0:    a = 16'd12868;
      5'd1:    a = 16'd7596;
      5'd2:    a = 16'd4014;
      5'd3:    a = 16'd2037;
      5'd4:    a = 16'd1023;
      5'd5:    a = 16'd512;
      5'd6:    a = 16'd256;
      5'd7:    a = 16'd128;
      5'd8:    a = 16'd64;
      5'd9:    a = 16'd32;
      5'd10:   a = 16'd16;
      5'd11:   a = 16'd8;
      5'd12:   a = 16'd4;
      5'd13:   a = 16'd2;
      5'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

### design/mppt_smul.sv
module mppt_smul #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic            busy,
  output logic [WA+WB-1:0] prod
);
  localparam int CW = $clog2(WB + 1);

  logic [WA+WB-1:0] a_sh;
  logic [WB-1:0]    b_sh;
  logic [CW-1:0]    cnt;

  assign busy = (cnt != '0);

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt  <= CW'(WB);
      prod <= '0;
      a_sh <= (WA+WB)'(a);
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        prod <= prod + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - 1'b1;
    end
  end
endmodule

### design/mppt_div5.sv
module mppt_div5 #(
  parameter int W = 22
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  output logic         busy,
  output logic [W-1:0] quot
);
  localparam int CW = $clog2(W + 1);
  localparam logic [3:0] Divisor = 4'd5;

  logic [2:0]    rem;
  logic [3:0]    trial;
  logic [CW-1:0] cnt;

  assign busy  = (cnt != '0);
  assign trial = {rem, quot[W-1]};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt  <= CW'(W);
      rem  <= '0;
      quot <= dividend;
    end else if (busy) begin
      if (trial >= Divisor) begin
        rem  <= 3'(trial - Divisor);
        quot <= {quot[W-2:0], 1'b1};
      end else begin
        rem  <= trial[2:0];
        quot <= {quot[W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
    end
  end
endmodule

### design/mppt_cordic.sv
module mppt_cordic #(
  parameter int ITER = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mppt_pkg::VW-1:0]   v,
  input  logic signed [mppt_pkg::VW:0] dv,
  output logic                      busy,
  output logic signed [mppt_pkg::ZW-1:0] z
);
  import mppt_pkg::*;

  localparam int IW = $clog2(ITER + 1);

  logic signed [XW-1:0] x, y, xs, ys;
  logic [IW-1:0]        idx;
  logic signed [ZW-1:0] ang;

  assign xs  = x >>> idx;
  assign ys  = y >>> idx;
  assign ang = $signed(angle_q14(ANGLE_IDX_W'(idx)));

  // vectoring mode, one rotation per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      idx  <= '0;
      z    <= '0;
      x    <= $signed({(XW-VW-16)'(0), v, 16'd0});
      y    <= $signed({{(XW-VW-17){dv[VW]}}, dv, 16'd0});
    end else if (busy) begin
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + ang;
      end else if (y < 0) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - ang;
      end
      idx <= idx + 1'b1;
      if (idx == IW'(ITER - 1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

### design/mppt_perturb_observe_dynamic_step.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+----------------------------------------
// input    | in_valid / in_stall   | panel_voltage, panel_current (Q8.8)
// output   | out_valid / out_stall | duty_out, best_power, best_duty
// config   | APB psel/penable      | paddr, pwdata, prdata (4 registers)
//
// For each request the CORDIC runs one rotation a cycle beside the bit-serial
// power multiplier and the base_step/10 divider; once all three are done, the
// step correction goes through a serial multiply and a serial divide by five.
// The block holds one request at a time; in_stall is high while it works.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its commit waits until the output register is free.
// Reset (rst, synchronous) loads the register defaults and the tracker state.
module mppt_perturb_observe_dynamic_step #(
  parameter int CORDIC_ITERATIONS = mppt_pkg::CORDIC_ITER_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [mppt_pkg::VW-1:0]   panel_voltage,
  input  logic [mppt_pkg::VW-1:0]   panel_current,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [mppt_pkg::DW-1:0]   duty_out,
  output logic [mppt_pkg::PW-1:0]   best_power,
  output logic [mppt_pkg::DW-1:0]   best_duty,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [3:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import mppt_pkg::*;

  typedef enum logic [2:0] {IDLE, WORK, DMUL, DIV, UPD} state_t;
  state_t state;

  // configuration registers
  logic [DW-1:0] start_duty, duty_max, duty_min;
  logic [BW-1:0] base_step;
  // tracker state
  logic [PW-1:0] last_power, peak_power;
  logic [VW-1:0] last_voltage;
  logic [DW-1:0] current_duty, step_size, peak_duty;
  logic          direction_up;

  // request latch
  logic [VW-1:0] v_in;
  logic          z_neg;

  reg_idx_t cfg_idx;
  logic     cfg_wr;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_START_DUTY:   prdata = 32'(start_duty);
      REG_DUTY_MAX:     prdata = 32'(duty_max);
      REG_DUTY_MIN:     prdata = 32'(duty_min);
      REG_BASE_STEP:    prdata = 32'(base_step);
      default:          prdata = '0;
    endcase
  end

  // arithmetic units
  logic                  start_in, start_dm, start_dv;
  logic                  pm_busy, cd_busy, lo_busy, dm_busy, dv_busy;
  logic [PW-1:0]         power;
  logic signed [ZW-1:0]  z;
  logic [ZMW-1:0]        z_mag;
  logic [DPW-1:0]        dprod;
  logic [DPW:0]          dround;
  logic [TW-1:0]         q;
  logic [BW-2:0]         lo_q;

  assign start_in = (state == IDLE) && in_valid;
  assign in_stall = (state != IDLE);

  mppt_smul #(.WA(VW), .WB(VW)) u_pmul (
    .clk, .rst, .start(start_in), .a(panel_voltage), .b(panel_current),
    .busy(pm_busy), .prod(power)
  );

  mppt_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
    .clk, .rst, .start(start_in), .v(panel_voltage),
    .dv($signed({1'b0, panel_voltage}) - $signed({1'b0, last_voltage})),
    .busy(cd_busy), .z(z)
  );

  // base_step/10 as (base_step>>1)/5
  mppt_div5 #(.W(BW - 1)) u_lo (
    .clk, .rst, .start(start_in), .dividend(base_step[BW-1:1]),
    .busy(lo_busy), .quot(lo_q)
  );

  mppt_smul #(.WA(BW), .WB(ZMW)) u_dmul (
    .clk, .rst, .start(start_dm), .a(base_step), .b(z_mag),
    .busy(dm_busy), .prod(dprod)
  );

  assign dround = (DPW+1)'(dprod) + ROUND_HALF;

  mppt_div5 #(.W(TW)) u_div (
    .clk, .rst, .start(start_dv), .dividend(dround[DPW:15]),
    .busy(dv_busy), .quot(q)
  );

  // zero voltage forces a zero angle term
  always_comb begin
    if (v_in == '0) begin
      z_mag = '0;
    end else if (z < 0) begin
      z_mag = ZMW'(-z);
    end else begin
      z_mag = ZMW'(z);
    end
  end

  assign start_dm = (state == WORK) && !pm_busy && !cd_busy && !lo_busy;
  assign start_dv = (state == DMUL) && !dm_busy;

  // step and duty update
  logic signed [SW-1:0] delta, step_raw, step_c, lo_s, hi_s, duty_raw, duty_c;
  logic [BW+3:0]        hi_w;
  logic                 dir_a, dir_b, out_free;

  always_comb begin
    delta    = z_neg ? -$signed(SW'(q)) : $signed(SW'(q));
    step_raw = $signed(SW'(step_size)) - delta;
    lo_s     = $signed(SW'(lo_q));
    hi_w     = ((BW+4)'(base_step) << 3) + ((BW+4)'(base_step) << 1);
    hi_s     = (hi_w > (BW+4)'(DUTY_ALL_ONES)) ? $signed(SW'(DUTY_ALL_ONES))
                                              : $signed(SW'(hi_w));
    if (step_raw > hi_s) begin
      step_c = hi_s;
    end else if (step_raw < lo_s) begin
      step_c = lo_s;
    end else begin
      step_c = step_raw;
    end
    dir_a    = (power < last_power) ? !direction_up : direction_up;
    duty_raw = dir_a ? $signed(SW'(current_duty)) + step_c
                     : $signed(SW'(current_duty)) - step_c;
    dir_b    = dir_a;
    duty_c   = duty_raw;
    if (duty_raw > $signed(SW'(duty_max))) begin
      duty_c = $signed(SW'(duty_max));
      dir_b  = !dir_a;
    end else if (duty_raw < $signed(SW'(duty_min))) begin
      duty_c = $signed(SW'(duty_min));
      dir_b  = !dir_a;
    end
  end

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      out_valid    <= 1'b0;
      start_duty   <= 24'd8388608;
      duty_max     <= 24'd15938355;
      duty_min     <= 24'd838861;
      base_step    <= 21'd16777;
      current_duty <= 24'd8388608;
      step_size    <= 24'd16777;
      last_power   <= '0;
      last_voltage <= '0;
      direction_up <= 1'b1;
      peak_power   <= '0;
      peak_duty    <= '0;
    end else begin
      // drop the taken result unless a new one is committed this cycle
      if (out_valid && !out_stall && state != UPD) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_START_DUTY: begin
            start_duty   <= pwdata[DW-1:0];
            current_duty <= pwdata[DW-1:0];
          end
          REG_DUTY_MAX: duty_max <= pwdata[DW-1:0];
          REG_DUTY_MIN: duty_min <= pwdata[DW-1:0];
          REG_BASE_STEP: begin
            base_step <= pwdata[BW-1:0];
            step_size <= DW'(pwdata[BW-1:0]);
          end
          default: ;
        endcase
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            v_in  <= panel_voltage;
            state <= WORK;
          end
        end
        WORK: begin
          if (start_dm) begin
            z_neg  <= (z < 0);
            state  <= DMUL;
          end
        end
        DMUL: begin
          if (start_dv) begin
            state <= DIV;
          end
        end
        DIV: begin
          if (!dv_busy) begin
            state <= UPD;
          end
        end
        UPD: begin
          // commit only once the output register can take the result
          if (out_free) begin
            step_size    <= step_c[DW-1:0];
            direction_up <= dir_b;
            current_duty <= duty_c[DW-1:0];
            duty_out     <= duty_c[DW-1:0];
            last_power   <= power;
            last_voltage <= v_in;
            if (power > peak_power) begin
              peak_power <= power;
              peak_duty  <= current_duty;
              best_power <= power;
              best_duty  <= current_duty;
            end else begin
              best_power <= peak_power;
              best_duty  <= peak_duty;
            end
            out_valid <= 1'b1;
            state     <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_duty_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> duty_out == current_duty)
    else $error("duty_out differs from committed duty");

  a_peak_matches: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> best_power == peak_power && best_duty == peak_duty)
    else $error("best power record differs from output");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> peak_power >= $past(peak_power))
    else $error("peak power decreased");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    state == UPD |-> !pm_busy && !cd_busy && !dm_busy && !dv_busy)
    else $error("arithmetic unit busy at commit");
endmodule

### verif/mppt_perturb_observe_dynamic_step_tb.sv
`timescale 1ns / 100ps

module mppt_perturb_observe_dynamic_step_tb;
  import mppt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LATENCY = 80;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VW-1:0] panel_voltage = '0;
  logic [VW-1:0] panel_current = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DW-1:0] duty_out;
  logic [PW-1:0] best_power;
  logic [DW-1:0] best_duty;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct packed {
    logic [DW-1:0] duty;
    logic [PW-1:0] power;
    logic [DW-1:0] pduty;
  } tracker_out_t;

  // Tracker copy kept by the testbench
  logic [DW-1:0] cfg_init_duty, cfg_duty_max, cfg_duty_min;
  logic [BW-1:0] cfg_base_step;
  logic [PW-1:0] trk_last_power, trk_peak_power;
  logic [VW-1:0] trk_last_volt;
  logic [DW-1:0] trk_duty, trk_step, trk_peak_duty;
  logic trk_up;

  tracker_out_t pending_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;   // no idling in the final stretch
  bit sink_run = 1'b0;

  always #5 clk = ~clk;

  mppt_perturb_observe_dynamic_step u_top (.*);

  // Reset values of the tracker copy
  task automatic tracker_reset();
    cfg_init_duty = 24'd8388608;
    cfg_duty_max = 24'd15938355;
    cfg_duty_min = 24'd838861;
    cfg_base_step = 21'd16777;
    trk_last_power = '0;
    trk_last_volt = '0;
    trk_duty = cfg_init_duty;
    trk_up = 1'b1;
    trk_step = 24'(cfg_base_step);
    trk_peak_power = '0;
    trk_peak_duty = '0;
  endtask

  // floor shift for signed values
  function automatic longint asr_floor(longint a, int s);
    return a >>> s;
  endfunction

  // CORDIC vectoring atan(y/x), Q2.14
  function automatic longint atan_q14(longint x, longint y);
    longint z, xs, ys;
    longint tab[15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                        64, 32, 16, 8, 4, 2, 1};
    z = 0;
    for (int i = 0; i < CORDIC_ITER_DEF; i++) begin
      xs = asr_floor(x, i);
      ys = asr_floor(y, i);
      if (y > 0) begin
        x += ys; y -= xs; if (i < 15) z += tab[i];
      end else if (y < 0) begin
        x -= ys; y += xs; if (i < 15) z -= tab[i];
      end
    end
    return z;
  endfunction

  // Advance the tracker copy by one sample and return the expected result
  function automatic tracker_out_t track_sample(logic [VW-1:0] v, logic [VW-1:0] c);
    tracker_out_t r;
    logic [PW-1:0] p;
    longint ang, prod, mag, q, step, lo, hi, duty;
    p = PW'(v) * PW'(c);
    ang = 0;
    if (v != 0)
      ang = atan_q14(longint'(v) * 65536, (longint'(v) - longint'(trk_last_volt)) * 65536);
    prod = longint'(cfg_base_step) * ang;
    mag = prod < 0 ? -prod : prod;
    q = (mag + 81920) / 163840;
    step = longint'(trk_step) - (prod < 0 ? -q : q);
    lo = longint'(cfg_base_step) / 10;
    hi = longint'(cfg_base_step) * 10;
    if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
    if (step > hi) step = hi;
    else if (step < lo) step = lo;
    trk_step = DW'(step);
    if (p < trk_last_power) trk_up = ~trk_up;
    duty = trk_up ? longint'(trk_duty) + step : longint'(trk_duty) - step;
    if (duty > longint'(cfg_duty_max)) begin
      duty = cfg_duty_max; trk_up = ~trk_up;
    end else if (duty < longint'(cfg_duty_min)) begin
      duty = cfg_duty_min; trk_up = ~trk_up;
    end
    if (p > trk_peak_power) begin
      trk_peak_duty = trk_duty;
      trk_peak_power = p;
    end
    trk_last_power = p;
    trk_last_volt = v;
    trk_duty = DW'(duty);
    r.duty = trk_duty;
    r.power = trk_peak_power;
    r.pduty = trk_peak_duty;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Random idle burst: drop valid, then wait
  task automatic idle_burst();
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  // Send one request and predict its result; valid stays up until the
  // next request, an idle burst or a drain replaces it
  task automatic send_sample(logic [VW-1:0] v, logic [VW-1:0] c);
    idle_burst();
    in_valid <= 1'b1;
    panel_voltage <= v;
    panel_current <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(track_sample(v, c));
  endtask

  // Hold until every expected result has come, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  // APB write: setup then access, then back to idle
  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= 4'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_START_DUTY: begin
        cfg_init_duty = value[DW-1:0]; trk_duty = cfg_init_duty;
      end
      REG_DUTY_MAX: cfg_duty_max = value[DW-1:0];
      REG_DUTY_MIN: cfg_duty_min = value[DW-1:0];
      REG_BASE_STEP: begin
        cfg_base_step = value[BW-1:0]; trk_step = 24'(cfg_base_step);
      end
      default: ;
    endcase
  endtask

  // Receiver: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    tracker_out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result count", 1, 0);
        end else begin
          want = pending_results.pop_front();
          if (duty_out !== want.duty) report_mismatch("duty_out", duty_out, want.duty);
          if (best_power !== want.power)
            report_mismatch("best_power", best_power, want.power);
          if (best_duty !== want.pduty) report_mismatch("best_duty", best_duty, want.pduty);
        end
      end
      if (quiet) out_stall <= 1'b0;
      else if ($urandom_range(3) == 0) out_stall <= ~out_stall;
    end
  end

  // Watchdog: count cycles with no accept on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Directed: field extremes, zero voltage, power fall, equal power
  task automatic test_directed();
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h0000, 16'hFFFF);
    send_sample(16'hFFFF, 16'hFFFF);
    send_sample(16'hFFFF, 16'h0001);
    send_sample(16'h0001, 16'hFFFF);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h0100, 16'h0100);
    send_sample(16'hFFFF, 16'h5555);
    send_sample(16'h5555, 16'hAAAA);
    send_sample(16'hAAAA, 16'h5555);
    drain();
  endtask

  // Duty limits hit on both sides, with a large step
  task automatic test_duty_limits();
    reg_write(REG_BASE_STEP, 32'd1677721);
    reg_write(REG_DUTY_MAX, 32'd9000000);
    reg_write(REG_DUTY_MIN, 32'd8000000);
    reg_write(REG_START_DUTY, 32'd8500000);
    for (int i = 0; i < 12; i++)
      send_sample(VW'(16'h1000 + i * 300), VW'(16'h2000 - i * 400));
    drain();
  endtask

  // Inverted limits, zero base step, upper bits ignored
  task automatic test_odd_settings();
    reg_write(REG_DUTY_MAX, 32'hFF00_0010);
    reg_write(REG_DUTY_MIN, 32'h0000_0020);
    reg_write(REG_BASE_STEP, 32'hFFE0_0000);
    reg_write(REG_START_DUTY, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send_sample(VW'($urandom), VW'($urandom));
    drain();
    reg_write(REG_DUTY_MAX, 32'hFFFFFF);
    reg_write(REG_DUTY_MIN, 32'd0);
    reg_write(REG_BASE_STEP, 32'd1);
    reg_write(REG_START_DUTY, 32'd0);
    for (int i = 0; i < 6; i++) send_sample(VW'($urandom), VW'($urandom));
    drain();
  endtask

  // Random: mostly slow drifts near a power peak, some wild noise
  task automatic test_random(int n, logic [31:0] bstep);
    int v, c;
    reg_write(REG_DUTY_MAX, 32'(DW'($urandom_range(24'hFFFFFF, 24'hA00000))));
    reg_write(REG_DUTY_MIN, 32'($urandom_range(24'h400000)));
    reg_write(REG_BASE_STEP, bstep);
    reg_write(REG_START_DUTY, 32'h800000);
    v = $urandom_range(65535);
    c = $urandom_range(65535);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(4) == 0) begin
        v = $urandom_range(65535);
        c = $urandom_range(65535);
      end else begin
        v = v + $urandom_range(400) - 200;
        c = c + $urandom_range(400) - 200;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        if (c < 0) c = 0;
        if (c > 65535) c = 65535;
      end
      send_sample(VW'(v), VW'(c));
    end
    drain();
  endtask

  initial begin
    tracker_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_duty_limits();
    test_odd_settings();
    test_random(200, 32'd16777);
    test_random(200, 32'($urandom_range(1677721, 1)));
    test_random(150, 32'd1677721);
    quiet = 1'b1;
    test_random(100, 32'd200000);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
